/* rtl/hrjd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrjd_pkg
// Shared types, register codes, field widths and constants of the heading
// run / jibe detector.
// ----------------------------------------------------------------------------
package hrjd_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 18;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SAMPLE_RATE    = 3'd0,
        REG_MEAN_TIME      = 3'd1,
        REG_RUN_DELAY      = 3'd2,
        REG_MOVING_MIN     = 3'd3,
        REG_STANDSTILL_MAX = 3'd4,
        REG_STRAIGHT_MAX   = 3'd5,
        REG_JIBE_MIN       = 3'd6
    } t_cfg_reg;

    // Register widths and reset values
    localparam int RATE_W   = 6;
    localparam int SECS_W   = 8;
    localparam int SPEED_W  = 18;
    localparam int DEVCFG_W = 16;

    localparam logic [RATE_W-1:0]   RST_SAMPLE_RATE    = 6'd5;
    localparam logic [SECS_W-1:0]   RST_MEAN_TIME      = 8'd15;
    localparam logic [SECS_W-1:0]   RST_RUN_DELAY      = 8'd10;
    localparam logic [SPEED_W-1:0]  RST_MOVING_MIN     = 18'd4000;
    localparam logic [SPEED_W-1:0]  RST_STANDSTILL_MAX = 18'd1000;
    localparam logic [DEVCFG_W-1:0] RST_STRAIGHT_MAX   = 16'd1000;
    localparam logic [DEVCFG_W-1:0] RST_JIBE_MIN       = 16'd5000;

    // Rate used when the rate register holds zero
    localparam logic [RATE_W-1:0]   DEFAULT_RATE = 6'd5;

    // Stream fields
    localparam int HEADING_W     = 16;
    localparam int INDEX_FIELD_W = 20;
    localparam int COUNT_OUT_W   = 16;
    localparam int IDX_OUT_W     = 21;
    localparam int DEV_OUT_W     = 20;
    localparam int S_TDATA_W     = 56;
    localparam int M_TDATA_W     = 136;

    // Arithmetic
    localparam int MEAN_W    = 48;
    localparam int OFFSET_W  = 32;
    localparam int DELAY_W   = 32;
    localparam int HEAD_UW_W = 34;              // unwrapped heading, signed
    localparam int NDIV_W    = RATE_W + SECS_W; // samples in the mean window

    localparam int UNWRAP_LIMIT = 30000;
    localparam int FULL_TURN    = 36000;
    localparam logic [DEV_OUT_W-1:0] DEV_SAT = 20'd1000000;

    // Parameter defaults
    localparam int DEF_COUNT_WIDTH    = 16;
    localparam int DEF_INDEX_WIDTH    = 20;
    localparam int DEF_MEAN_FRAC_BITS = 8;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

/* rtl/heading_run_jibe_detector_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_run_jibe_detector_core
// Unwraps GPS heading, keeps an exponential heading mean and tracks straight
// runs, jibes and standstill restarts, one result per sample.
// ----------------------------------------------------------------------------
//  channel   | direction | signals                        | content
//  ----------+-----------+--------------------------------+---------------------
//  s_axis    | in        | tvalid, tready, tdata[55:0]    | one GPS sample
//  m_axis    | out       | tvalid, tready, tdata[135:0]   | one result per sample
//  cfg       | in        | we, addr[2:0], data[17:0]      | register writes
//
//  A sample passes the sequencer states unwrap, diff, div, mean, dev and decide;
//  in div the bit-serial mean divider (DW = 49 with MEAN_FRAC_BITS = 8) runs.
//  Reset is synchronous, active low, and restores config, tracking and sequencer state.
//  s_axis_tready is high only while the sequencer is idle.
//  The result sits in an output register; a stalled output holds the last
//  sequencer step until the previous result has been taken.
// ----------------------------------------------------------------------------
module heading_run_jibe_detector_core #(
    parameter int COUNT_WIDTH    = hrjd_pkg::DEF_COUNT_WIDTH,
    parameter int INDEX_WIDTH    = hrjd_pkg::DEF_INDEX_WIDTH,
    parameter int MEAN_FRAC_BITS = hrjd_pkg::DEF_MEAN_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample in: heading_cdeg[15:0], speed_mmps[33:16], sample_index[53:34]
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [hrjd_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // result: run_number[15:0], run_started[16], run_ended[17],
    // on_straight[18], jibes_seen[34:19], arms_seen[50:35],
    // restarts_seen[66:51], jibe_at_index[87:67], armed_at_index[108:88],
    // deviation_cdeg[128:109]
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [hrjd_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [hrjd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [hrjd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int F      = MEAN_FRAC_BITS;
    localparam int T_W    = hrjd_pkg::HEAD_UW_W + F;
    localparam int DW     = ((T_W > hrjd_pkg::MEAN_W) ? T_W : hrjd_pkg::MEAN_W) + 1;
    localparam int IDX_W  = (INDEX_WIDTH < hrjd_pkg::INDEX_FIELD_W) ?
                            INDEX_WIDTH : hrjd_pkg::INDEX_FIELD_W;
    localparam int CW     = COUNT_WIDTH;
    localparam int HW     = hrjd_pkg::HEADING_W;
    localparam int SW     = hrjd_pkg::SPEED_W;
    localparam int MW     = hrjd_pkg::MEAN_W;
    localparam int OW     = hrjd_pkg::OFFSET_W;
    localparam int DLW    = hrjd_pkg::DELAY_W;
    localparam int NW     = hrjd_pkg::NDIV_W;
    localparam int XW     = hrjd_pkg::IDX_OUT_W;
    localparam int COW    = hrjd_pkg::COUNT_OUT_W;
    localparam int VW     = hrjd_pkg::DEV_OUT_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UNWRAP = 7'b0000010,
        S_DIFF   = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_MEAN   = 7'b0010000,
        S_DEV    = 7'b0100000,
        S_DECIDE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [hrjd_pkg::RATE_W-1:0]   r_cfg_rate;
    logic [hrjd_pkg::SECS_W-1:0]   r_cfg_mean_time;
    logic [hrjd_pkg::SECS_W-1:0]   r_cfg_run_delay;
    logic [SW-1:0]                 r_cfg_moving_min;
    logic [SW-1:0]                 r_cfg_stand_max;
    logic [hrjd_pkg::DEVCFG_W-1:0] r_cfg_straight_max;
    logic [hrjd_pkg::DEVCFG_W-1:0] r_cfg_jibe_min;

    // Sample
    logic [HW-1:0]    r_hd;
    logic [SW-1:0]    r_spd;
    logic [IDX_W-1:0] r_idx;

    // Tracking state
    logic [HW-1:0]        r_prev_hd;
    logic [OW-1:0]        r_offset;
    logic [MW-1:0]        r_mean;
    logic [DLW-1:0]       r_delay;
    logic [CW-1:0]        r_run_cnt, r_jibe_cnt, r_arm_cnt, r_restart_cnt;
    logic                 r_was_moving, r_was_stopped, r_straight;
    logic signed [XW-1:0] r_jibe_idx, r_arm_idx;

    // Work registers
    logic signed [DW-1:0] r_target;
    logic                 r_neg;
    logic [DW-2:0]        r_dev;

    // Output register
    logic                 r_out_valid;
    logic [hrjd_pkg::M_TDATA_W-1:0] r_out_data;

    logic accept_in, out_free, decide_fire;

    assign accept_in   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_m_axis_tready;
    assign decide_fire = (r_state == S_DECIDE) && out_free;

    // ---------------- rate dependent values ----------------
    logic [hrjd_pkg::RATE_W-1:0] rate;
    logic [NW-1:0]               n_win_raw, n_win;
    logic [DLW-1:0]              start_at, reload;

    assign rate      = (r_cfg_rate == '0) ? hrjd_pkg::DEFAULT_RATE : r_cfg_rate;
    assign n_win_raw = NW'(r_cfg_mean_time * rate);
    assign n_win     = (n_win_raw == '0) ? NW'(1) : n_win_raw;
    assign start_at  = DLW'(r_cfg_run_delay * rate);
    assign reload    = start_at - DLW'(rate);

    // ---------------- unwrap ----------------
    logic signed [HW:0]          jump;
    logic [OW-1:0]               offset_nx;
    logic signed [hrjd_pkg::HEAD_UW_W-1:0] h_uw;

    assign jump = $signed({1'b0, r_hd}) - $signed({1'b0, r_prev_hd});

    always_comb begin
        offset_nx = r_offset;
        if (jump > (HW+1)'(hrjd_pkg::UNWRAP_LIMIT)) begin
            offset_nx = r_offset - OW'(hrjd_pkg::FULL_TURN);
        end else if (jump < -(HW+1)'(hrjd_pkg::UNWRAP_LIMIT)) begin
            offset_nx = r_offset + OW'(hrjd_pkg::FULL_TURN);
        end
    end

    assign h_uw = $signed(hrjd_pkg::HEAD_UW_W'({1'b0, r_hd}))
                + hrjd_pkg::HEAD_UW_W'($signed(offset_nx));

    // ---------------- difference toward the divider ----------------
    logic signed [DW-1:0] mean_ext, diff_tm;
    logic [DW-1:0]        diff_mag;

    assign mean_ext = DW'($signed(r_mean));
    assign diff_tm  = r_target - mean_ext;
    assign diff_mag = diff_tm[DW-1] ? DW'(-diff_tm) : DW'(diff_tm);

    hrjd_pkg::t_div_status div_status;
    logic [DW-1:0]         div_quo;

    hrjd_serial_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIFF),
        .i_dividend (diff_mag),
        .i_divisor  (n_win),
        .o_status   (div_status),
        .o_quotient (div_quo)
    );

    // ---------------- mean update and deviation ----------------
    logic [MW-1:0]        quo_signed;
    logic signed [DW-1:0] dev_raw;

    assign quo_signed = r_neg ? MW'(-div_quo) : MW'(div_quo);
    assign dev_raw    = mean_ext - r_target;

    // ---------------- decisions ----------------
    logic                 moving;
    logic                 wm, ws, restart, straight_hit, jibe_hit, start_run;
    logic                 arm1;
    logic                 sf1;
    logic [DLW-1:0]       delay0, delay1, delay2;
    logic [DW-2:0]        straight_lim, jibe_lim;
    logic [CW-1:0]        n_run_cnt, n_jibe_cnt, n_arm_cnt, n_restart_cnt;
    logic                 n_was_moving, n_was_stopped, n_straight;
    logic signed [XW-1:0] n_jibe_idx, n_arm_idx;
    logic [DLW-1:0]       n_delay;
    logic [DW-2:0]        devq_full;
    logic [VW-1:0]        devq;

    assign straight_lim = (DW-1)'(r_cfg_straight_max) << F;
    assign jibe_lim     = (DW-1)'(r_cfg_jibe_min) << F;

    always_comb begin
        moving = r_spd > r_cfg_moving_min;
        wm     = r_was_moving || moving;
        ws     = r_was_stopped || ((r_spd < r_cfg_stand_max) && wm);

        // standstill restart
        restart       = ws && moving;
        n_was_moving  = restart ? 1'b0 : wm;
        n_was_stopped = restart ? 1'b0 : ws;
        delay0        = restart ? reload : r_delay;
        n_restart_cnt = restart ? r_restart_cnt + 1'b1 : r_restart_cnt;

        // arming on a straight course
        straight_hit = (r_dev < straight_lim) && moving;
        arm1         = straight_hit && !r_straight;
        sf1          = r_straight || straight_hit;

        // jibe ends a run
        jibe_hit   = (r_dev > jibe_lim) && sf1;
        delay1     = jibe_hit ? '0 : delay0;
        n_jibe_cnt = jibe_hit ? r_jibe_cnt + 1'b1 : r_jibe_cnt;

        // delay expiry starts a run
        delay2    = delay1 + 1'b1;
        start_run = delay2 == start_at;
        n_delay   = delay2;
        n_run_cnt = start_run ? r_run_cnt + 1'b1 : r_run_cnt;

        n_straight = start_run ? moving : (sf1 && !jibe_hit);

        n_arm_cnt = r_arm_cnt + CW'(arm1) + CW'(start_run && moving);
        n_arm_idx = (arm1 || (start_run && moving)) ?
                    $signed(XW'(r_idx)) : r_arm_idx;
        n_jibe_idx = jibe_hit ? $signed(XW'(r_idx)) : r_jibe_idx;

        // whole centidegrees, saturated
        devq_full = r_dev >> F;
        devq      = (devq_full > (DW-1)'(hrjd_pkg::DEV_SAT)) ?
                    hrjd_pkg::DEV_SAT : VW'(devq_full);
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept_in) n_state = S_UNWRAP;
            S_UNWRAP: n_state = S_DIFF;
            S_DIFF:   n_state = S_DIV;
            S_DIV:    if (div_status.done) n_state = S_MEAN;
            S_MEAN:   n_state = S_DEV;
            S_DEV:    n_state = S_DECIDE;
            S_DECIDE: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- configuration writes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rate         <= hrjd_pkg::RST_SAMPLE_RATE;
            r_cfg_mean_time    <= hrjd_pkg::RST_MEAN_TIME;
            r_cfg_run_delay    <= hrjd_pkg::RST_RUN_DELAY;
            r_cfg_moving_min   <= hrjd_pkg::RST_MOVING_MIN;
            r_cfg_stand_max    <= hrjd_pkg::RST_STANDSTILL_MAX;
            r_cfg_straight_max <= hrjd_pkg::RST_STRAIGHT_MAX;
            r_cfg_jibe_min     <= hrjd_pkg::RST_JIBE_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                hrjd_pkg::REG_SAMPLE_RATE:
                    r_cfg_rate <= i_cfg_data[hrjd_pkg::RATE_W-1:0];
                hrjd_pkg::REG_MEAN_TIME:
                    r_cfg_mean_time <= i_cfg_data[hrjd_pkg::SECS_W-1:0];
                hrjd_pkg::REG_RUN_DELAY:
                    r_cfg_run_delay <= i_cfg_data[hrjd_pkg::SECS_W-1:0];
                hrjd_pkg::REG_MOVING_MIN:
                    r_cfg_moving_min <= i_cfg_data[SW-1:0];
                hrjd_pkg::REG_STANDSTILL_MAX:
                    r_cfg_stand_max <= i_cfg_data[SW-1:0];
                hrjd_pkg::REG_STRAIGHT_MAX:
                    r_cfg_straight_max <= i_cfg_data[hrjd_pkg::DEVCFG_W-1:0];
                hrjd_pkg::REG_JIBE_MIN:
                    r_cfg_jibe_min <= i_cfg_data[hrjd_pkg::DEVCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sample capture and work registers ----------------
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_hd  <= i_s_axis_tdata[HW-1:0];
            r_spd <= i_s_axis_tdata[HW +: SW];
            r_idx <= i_s_axis_tdata[HW+SW +: IDX_W];
        end
        if (r_state == S_UNWRAP) begin
            r_target <= DW'(h_uw) <<< F;
        end
        if (r_state == S_DIFF) begin
            r_neg <= diff_tm[DW-1];
        end
        if (r_state == S_DEV) begin
            r_dev <= dev_raw[DW-1] ? (DW-1)'(-dev_raw) : (DW-1)'(dev_raw);
        end
    end

    // ---------------- tracking state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_hd     <= '0;
            r_offset      <= '0;
            r_mean        <= '0;
            r_delay       <= '0;
            r_run_cnt     <= '0;
            r_jibe_cnt    <= '0;
            r_arm_cnt     <= '0;
            r_restart_cnt <= '0;
            r_was_moving  <= 1'b0;
            r_was_stopped <= 1'b0;
            r_straight    <= 1'b0;
            r_jibe_idx    <= '1;
            r_arm_idx     <= '1;
        end else begin
            if (r_state == S_UNWRAP) begin
                r_prev_hd <= r_hd;
                r_offset  <= offset_nx;
            end
            if (r_state == S_MEAN) begin
                r_mean <= r_mean + quo_signed;
            end
            if (decide_fire) begin
                if (start_run) begin
                    r_mean <= r_target[MW-1:0];
                end
                r_delay       <= n_delay;
                r_run_cnt     <= n_run_cnt;
                r_jibe_cnt    <= n_jibe_cnt;
                r_arm_cnt     <= n_arm_cnt;
                r_restart_cnt <= n_restart_cnt;
                r_was_moving  <= n_was_moving;
                r_was_stopped <= n_was_stopped;
                r_straight    <= n_straight;
                r_jibe_idx    <= n_jibe_idx;
                r_arm_idx     <= n_arm_idx;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (decide_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (decide_fire) begin
            r_out_data <= {7'd0,
                           devq,
                           n_arm_idx,
                           n_jibe_idx,
                           COW'(n_restart_cnt),
                           COW'(n_arm_cnt),
                           COW'(n_jibe_cnt),
                           n_straight,
                           jibe_hit,
                           start_run,
                           COW'(n_run_cnt)};
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

/* rtl/hrjd_serial_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrjd_serial_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrjd_serial_div #(
    parameter int DIVIDEND_W = 49,
    parameter int DIVISOR_W  = hrjd_pkg::NDIV_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [DIVIDEND_W-1:0]   i_dividend,
    input  logic [DIVISOR_W-1:0]    i_divisor,
    output hrjd_pkg::t_div_status   o_status,
    output logic [DIVIDEND_W-1:0]   o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    // Shift in the next dividend bit and try to subtract
    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
            r_rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(DIVIDEND_W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

/* rtl/hrjd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrjd_checker
// Port-level checks of the heading run / jibe detector, bound to the core.
// ----------------------------------------------------------------------------
module hrjd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [hrjd_pkg::M_TDATA_W-1:0]    o_m_axis_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // One request at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("sample accepted while busy");

    // A jibe without a new run leaves the course unarmed
    a_jibe_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[17] && !o_m_axis_tdata[16] |->
            !o_m_axis_tdata[18])
        else $error("armed after jibe");

    // A jibe records a real sample index
    a_jibe_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[17] |-> !o_m_axis_tdata[87])
        else $error("jibe index missing");

endmodule

bind heading_run_jibe_detector_core hrjd_checker u_hrjd_checker (.*);
